// File: sv/mma_pkg.sv
// Shared types and constants of the matrix multiply-accumulate block.
`timescale 1ns / 1ps
package mma_pkg;

  // Field widths fixed by the item formats
  localparam int CMD_W = 2;
  localparam int POS_W = 3;
  localparam int AB_W  = 16;
  localparam int C_W   = 32;
  localparam int DIM_W = 4;
  localparam int REG_W = 2;
  localparam int PROD_W = 2 * AB_W;
  // Eight full-scale products plus the C entry fit in 36 bits
  localparam int ACC_W = 36;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_C  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd3;

  // Register indexes
  localparam logic [REG_W-1:0] REG_A_ROWS    = 2'd0;
  localparam logic [REG_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [REG_W-1:0] REG_B_COLS    = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFFFFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(64'sh80000000);

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [POS_W-1:0]       row;
    logic [POS_W-1:0]       col;
    logic signed [AB_W-1:0] value_ab;
    logic signed [C_W-1:0]  value_c;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0]      out_row;
    logic [POS_W-1:0]      out_col;
    logic signed [C_W-1:0] result;
    logic                  saturated;
    logic                  last;
  } rsp_t;

  typedef struct packed {
    logic [REG_W-1:0] index;
    logic [DIM_W-1:0] value;
  } cfg_t;

  // Operand token passed along the cell chain
  typedef struct packed {
    logic                   valid;
    logic signed [AB_W-1:0] a;
    logic [POS_W-1:0]       k;
    logic                   first;
    logic                   last;
  } token_t;

  // Element load broadcast to the cells
  typedef struct packed {
    logic                   b_we;
    logic                   c_we;
    logic [POS_W-1:0]       row;
    logic [POS_W-1:0]       col;
    logic signed [AB_W-1:0] value_ab;
    logic signed [C_W-1:0]  value_c;
  } load_t;

endpackage

// File: sv/mma_if.sv
// Handshake channel interfaces: request, response and register write.
`timescale 1ns / 1ps
interface mma_req_if;
  logic          valid;
  logic          ready;
  mma_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mma_rsp_if;
  logic          valid;
  logic          ready;
  mma_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mma_cfg_if;
  logic          valid;
  logic          ready;
  mma_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/mma_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/mma_cell.sv
// MAC cell: holds one column of B and of C, accumulates one result entry.
`timescale 1ns / 1ps
module mma_cell #(
  parameter int MAX_DIM = 8,
  parameter int IDX     = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mma_pkg::token_t                  tok_in,
  output mma_pkg::token_t                  tok_out,
  input  mma_pkg::load_t                   ld,
  input  logic [mma_pkg::POS_W-1:0]        row_i,
  input  logic [mma_pkg::DIM_W-1:0]        nc,
  output logic signed [mma_pkg::C_W-1:0]   res,
  output logic                             sat,
  output logic                             fin
);

  localparam int IW = $clog2(MAX_DIM);

  logic signed [mma_pkg::AB_W-1:0]   b_col [MAX_DIM];
  logic signed [mma_pkg::C_W-1:0]    c_col [MAX_DIM];
  logic                              p_valid;
  logic signed [mma_pkg::PROD_W-1:0] prod;
  logic                              p_first;
  logic                              p_last;
  logic signed [mma_pkg::ACC_W-1:0]  acc;
  logic signed [mma_pkg::ACC_W-1:0]  sum;
  logic signed [mma_pkg::ACC_W-1:0]  tot;
  logic                              mine;

  assign mine = (ld.col == mma_pkg::POS_W'(IDX));

  // Hand the token to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.a     <= tok_in.a;
    tok_out.k     <= tok_in.k;
    tok_out.first <= tok_in.first;
    tok_out.last  <= tok_in.last;
  end

  // Multiply stage; a zero A operand gives zero even against an unloaded B entry
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= tok_in.valid;
    end
    if (tok_in.a == '0) begin
      prod <= '0;
    end else begin
      prod <= mma_pkg::PROD_W'(tok_in.a) * mma_pkg::PROD_W'(b_col[tok_in.k[IW-1:0]]);
    end
    p_first <= tok_in.first;
    p_last  <= tok_in.last;
  end

  // Accumulate, then add the stored C entry on the last term
  always_comb begin
    sum = (p_first ? '0 : acc) + mma_pkg::ACC_W'(prod);
    tot = sum + mma_pkg::ACC_W'(c_col[row_i[IW-1:0]]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin <= 1'b0;
    end else begin
      fin <= p_valid && p_last;
    end
    if (p_valid) begin
      acc <= sum;
    end
    if (p_valid && p_last) begin
      priority if (tot > mma_pkg::SAT_HI) begin
        res <= mma_pkg::C_W'(mma_pkg::SAT_HI);
        sat <= 1'b1;
      end else if (tot < mma_pkg::SAT_LO) begin
        res <= mma_pkg::C_W'(mma_pkg::SAT_LO);
        sat <= 1'b1;
      end else begin
        res <= mma_pkg::C_W'(tot);
        sat <= 1'b0;
      end
    end
  end

  // Column storage: loads while idle, write-back after each entry
  always_ff @(posedge clk) begin
    if (ld.b_we && mine) begin
      b_col[ld.row[IW-1:0]] <= ld.value_ab;
    end
    priority if (ld.c_we && mine) begin
      c_col[ld.row[IW-1:0]] <= ld.value_c;
    end else if (p_valid && p_last && (mma_pkg::DIM_W'(IDX) < nc)) begin
      if (tot > mma_pkg::SAT_HI) begin
        c_col[row_i[IW-1:0]] <= mma_pkg::C_W'(mma_pkg::SAT_HI);
      end else if (tot < mma_pkg::SAT_LO) begin
        c_col[row_i[IW-1:0]] <= mma_pkg::C_W'(mma_pkg::SAT_LO);
      end else begin
        c_col[row_i[IW-1:0]] <= mma_pkg::C_W'(tot);
      end
    end
  end

endmodule

// File: sv/matrix_multiply_accumulate.sv
// Top level: sequencer, A store and a chain of MAC cells computing C += A * B.
// Load requests (cmd 0..2) write one element each. A compute request works row by
// row: the A row is read from a RAM one element a cycle and streamed down a
// chain of MAX_DIM MAC cells, each owning one column of B and C. Each result row
// is first computed (issue of the inner_dim terms, at least one, then the pass
// down the chain) and then output as b_cols entries, one entry a cycle when the
// response side is ready.
// Requests are taken only while no compute is running. Registers above MAX_DIM
// act as MAX_DIM.
`timescale 1ns / 1ps
module matrix_multiply_accumulate #(
  parameter int MAX_DIM = 8
) (
  input logic       clk,
  input logic       rst,
  mma_req_if.sink   req,
  mma_rsp_if.source rsp,
  mma_cfg_if.sink   cfg
);

  localparam int AW = $clog2(MAX_DIM * MAX_DIM);
  localparam int IW = $clog2(MAX_DIM);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]                  state;
  logic [mma_pkg::DIM_W-1:0]   a_rows, inner_dim, b_cols;
  logic [mma_pkg::DIM_W-1:0]   nr, nk, nc, klen;
  logic [mma_pkg::DIM_W-1:0]   i, k, j;
  logic                        req_acc, in_range, is_load;
  logic [AW-1:0]               waddr, raddr;
  logic [mma_pkg::AB_W-1:0]    a_rdata;
  logic                        iss_v, iss_first, iss_last, iss_zero;
  logic [mma_pkg::POS_W-1:0]   iss_k;
  mma_pkg::token_t             chain [MAX_DIM+1];
  mma_pkg::load_t              ld;
  logic signed [mma_pkg::C_W-1:0] res [MAX_DIM];
  logic                        sat [MAX_DIM];
  logic                        fin [MAX_DIM];
  logic                        emit_go;

  function automatic logic [mma_pkg::DIM_W-1:0] dim_of(input logic [mma_pkg::DIM_W-1:0] r);
    return (r > mma_pkg::DIM_W'(MAX_DIM)) ? mma_pkg::DIM_W'(MAX_DIM) : r;
  endfunction

  assign nr   = dim_of(a_rows);
  assign nk   = dim_of(inner_dim);
  assign nc   = dim_of(b_cols);
  assign klen = (nk == '0) ? mma_pkg::DIM_W'(1) : nk;

  // Register writes
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows    <= mma_pkg::DIM_RESET;
      inner_dim <= mma_pkg::DIM_RESET;
      b_cols    <= mma_pkg::DIM_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        mma_pkg::REG_A_ROWS:    a_rows    <= cfg.data.value;
        mma_pkg::REG_INNER_DIM: inner_dim <= cfg.data.value;
        mma_pkg::REG_B_COLS:    b_cols    <= cfg.data.value;
        default: ;
      endcase
    end
  end

  // Request decode
  assign req.ready = (state == ST_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign in_range  = (mma_pkg::DIM_W'(req.data.row) < mma_pkg::DIM_W'(MAX_DIM)) &&
                     (mma_pkg::DIM_W'(req.data.col) < mma_pkg::DIM_W'(MAX_DIM));
  assign is_load   = req_acc && in_range;
  assign waddr     = AW'(AW'(req.data.row) * AW'(MAX_DIM) + AW'(req.data.col));
  assign raddr     = AW'(AW'(i[IW-1:0]) * AW'(MAX_DIM) + AW'(k[IW-1:0]));

  always_comb begin
    ld.b_we     = is_load && (req.data.cmd == mma_pkg::CMD_LOAD_B);
    ld.c_we     = is_load && (req.data.cmd == mma_pkg::CMD_LOAD_C);
    ld.row      = req.data.row;
    ld.col      = req.data.col;
    ld.value_ab = req.data.value_ab;
    ld.value_c  = req.data.value_c;
  end

  mma_ram #(.WIDTH(mma_pkg::AB_W), .DEPTH(MAX_DIM * MAX_DIM)) u_a_store (
    .clk   (clk),
    .we    (is_load && (req.data.cmd == mma_pkg::CMD_LOAD_A)),
    .waddr (waddr),
    .wdata (req.data.value_ab),
    .raddr (raddr),
    .rdata (a_rdata)
  );

  // Head token: the registered A element arrives the cycle after its address
  always_comb begin
    chain[0].valid = iss_v;
    chain[0].a     = iss_zero ? '0 : a_rdata;
    chain[0].k     = iss_k;
    chain[0].first = iss_first;
    chain[0].last  = iss_last;
  end

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    mma_cell #(.MAX_DIM(MAX_DIM), .IDX(c)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain[c]),
      .tok_out (chain[c+1]),
      .ld      (ld),
      .row_i   (i[mma_pkg::POS_W-1:0]),
      .nc      (nc),
      .res     (res[c]),
      .sat     (sat[c]),
      .fin     (fin[c])
    );
  end

  assign emit_go = !rsp.valid || rsp.ready;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      iss_v <= 1'b0;
      rsp.valid <= 1'b0;
      i <= '0;
      k <= '0;
      j <= '0;
    end else begin
      iss_v <= 1'b0;
      // Drop the response once taken, unless a new entry replaces it
      if (rsp.valid && rsp.ready && !((state == ST_EMIT) && emit_go)) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_acc && (req.data.cmd == mma_pkg::CMD_COMPUTE) &&
              (nr != '0) && (nc != '0)) begin
            i <= '0;
            k <= '0;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          iss_v     <= 1'b1;
          iss_k     <= k[mma_pkg::POS_W-1:0];
          iss_first <= (k == '0);
          iss_last  <= (k == klen - 1'b1);
          iss_zero  <= (nk == '0);
          k <= k + 1'b1;
          if (k == klen - 1'b1) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (fin[MAX_DIM-1]) begin
            j <= '0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            rsp.valid <= 1'b1;
            rsp.data.out_row   <= i[mma_pkg::POS_W-1:0];
            rsp.data.out_col   <= j[mma_pkg::POS_W-1:0];
            rsp.data.result    <= res[j[IW-1:0]];
            rsp.data.saturated <= sat[j[IW-1:0]];
            rsp.data.last      <= (i == nr - 1'b1) && (j == nc - 1'b1);
            j <= j + 1'b1;
            if (j == nc - 1'b1) begin
              if (i == nr - 1'b1) begin
                state <= ST_IDLE;
              end else begin
                i <= i + 1'b1;
                k <= '0;
                state <= ST_ISSUE;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the matrix multiply-accumulate block.
`timescale 1ns / 1ps
module testbench;
  import mma_pkg::*;

  // Scoreboard: mirrors the stores and registers and predicts each result entry
  class mac_scoreboard;
    logic signed [AB_W-1:0] a_mem[8][8];
    logic signed [AB_W-1:0] b_mem[8][8];
    logic signed [C_W-1:0]  c_mem[8][8];
    bit a_set[8][8];
    bit b_set[8][8];
    bit c_set[8][8];
    int unsigned n_rows, n_inner, n_cols;
    rsp_t entries_due[$];
    int errors, results, sat_seen, computes;

    function new();
      n_rows = DIM_RESET;
      n_inner = DIM_RESET;
      n_cols = DIM_RESET;
    endfunction

    function int unsigned clip_dim(int unsigned v);
      return (v > 8) ? 8 : v;
    endfunction

    function void set_reg(cfg_t w);
      case (w.index)
        REG_A_ROWS:    n_rows = w.value;
        REG_INNER_DIM: n_inner = w.value;
        REG_B_COLS:    n_cols = w.value;
        default: ;
      endcase
    endfunction

    function void note_request(req_t r);
      int unsigned nr, nk, nc;
      longint acc;
      rsp_t e;
      case (r.cmd)
        CMD_LOAD_A: begin
          a_mem[r.row][r.col] = r.value_ab;
          a_set[r.row][r.col] = 1;
        end
        CMD_LOAD_B: begin
          b_mem[r.row][r.col] = r.value_ab;
          b_set[r.row][r.col] = 1;
        end
        CMD_LOAD_C: begin
          c_mem[r.row][r.col] = r.value_c;
          c_set[r.row][r.col] = 1;
        end
        default: begin
          computes++;
          nr = clip_dim(n_rows);
          nk = clip_dim(n_inner);
          nc = clip_dim(n_cols);
          for (int i = 0; i < nr; i++)
            for (int j = 0; j < nc; j++) begin
              acc = longint'(c_mem[i][j]);
              for (int k = 0; k < nk; k++)
                acc += longint'(a_mem[i][k]) * longint'(b_mem[k][j]);
              e.saturated = 0;
              if (acc > 64'sh7FFFFFFF) begin
                acc = 64'sh7FFFFFFF;
                e.saturated = 1;
              end
              if (acc < -64'sh80000000) begin
                acc = -64'sh80000000;
                e.saturated = 1;
              end
              c_mem[i][j] = acc[C_W-1:0];
              e.out_row = POS_W'(i);
              e.out_col = POS_W'(j);
              e.result = acc[C_W-1:0];
              e.last = (i == nr - 1) && (j == nc - 1);
              entries_due.push_back(e);
            end
        end
      endcase
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      results++;
      if (got.saturated) sat_seen++;
      if (entries_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result entry: %p", got);
        return;
      end
      e = entries_due.pop_front();
      if (got.out_row !== e.out_row || got.out_col !== e.out_col ||
          got.result !== e.result || got.saturated !== e.saturated ||
          got.last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display({"entry mismatch: expected row %0d col %0d %h sat %b last %b,",
                    " got row %0d col %0d %h sat %b last %b"},
                   e.out_row, e.out_col, e.result, e.saturated, e.last,
                   got.out_row, got.out_col, got.result, got.saturated, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   calm;
  int   issued;
  mac_scoreboard sb;

  mma_req_if req_ch();
  mma_rsp_if rsp_ch();
  mma_cfg_if cfg_ch();

  matrix_multiply_accumulate uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source),
    .cfg(cfg_ch.sink)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Hold off the response side at random
  always @(negedge clk) begin
    rsp_ch.ready <= calm || ($urandom_range(99) >= 37);
  end

  // Check every accepted result entry
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data);
  end

  // Present one request and hold it until accepted
  task send_request(input req_t r);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 37) begin
      req_ch.valid <= 0;
      @(negedge clk);
    end
    req_ch.valid <= 1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(r);
    issued++;
  endtask

  task write_reg(input logic [REG_W-1:0] index, input logic [DIM_W-1:0] value);
    cfg_t w;
    w.index = index;
    w.value = value;
    @(negedge clk);
    req_ch.valid <= 0;
    cfg_ch.valid <= 1;
    cfg_ch.data <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(w);
    @(negedge clk);
    cfg_ch.valid <= 0;
  endtask

  function logic signed [AB_W-1:0] pick_ab();
    case ($urandom_range(7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return '0;
      3: return -16'sd1;
      default: return AB_W'($urandom);
    endcase
  endfunction

  function logic signed [C_W-1:0] pick_c();
    case ($urandom_range(7))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return '0;
      default: return C_W'($urandom);
    endcase
  endfunction

  task load_one(input logic [CMD_W-1:0] cmd, input int row, input int col);
    req_t r;
    r.cmd = cmd;
    r.row = POS_W'(row);
    r.col = POS_W'(col);
    r.value_ab = pick_ab();
    r.value_c = pick_c();
    send_request(r);
  endtask

  // Load any entry the next compute reads that was never written, then compute
  task fill_and_compute();
    int unsigned nr, nk, nc;
    req_t r;
    nr = sb.clip_dim(sb.n_rows);
    nk = sb.clip_dim(sb.n_inner);
    nc = sb.clip_dim(sb.n_cols);
    if (nr > 0 && nc > 0) begin
      for (int i = 0; i < nr; i++)
        for (int k = 0; k < nk; k++)
          if (!sb.a_set[i][k]) load_one(CMD_LOAD_A, i, k);
      for (int k = 0; k < nk; k++)
        for (int j = 0; j < nc; j++)
          if (!sb.b_set[k][j]) load_one(CMD_LOAD_B, k, j);
      for (int i = 0; i < nr; i++)
        for (int j = 0; j < nc; j++)
          if (!sb.c_set[i][j]) load_one(CMD_LOAD_C, i, j);
    end
    r = '0;
    r.cmd = CMD_COMPUTE;
    r.row = POS_W'($urandom);
    r.col = POS_W'($urandom);
    r.value_ab = AB_W'($urandom);
    r.value_c = C_W'($urandom);
    send_request(r);
  endtask

  // Drain all due entries, then let a compute with no output finish
  task wait_idle();
    @(negedge clk);
    req_ch.valid <= 0;
    while (sb.entries_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task set_dims(input int r, input int k, input int c);
    write_reg(REG_A_ROWS, DIM_W'(r));
    write_reg(REG_INNER_DIM, DIM_W'(k));
    write_reg(REG_B_COLS, DIM_W'(c));
  endtask

  task directed_item(input logic [CMD_W-1:0] cmd, input int row, input int col,
                     input logic signed [AB_W-1:0] ab, input logic signed [C_W-1:0] cv);
    req_t r;
    r.cmd = cmd;
    r.row = POS_W'(row);
    r.col = POS_W'(col);
    r.value_ab = ab;
    r.value_c = cv;
    send_request(r);
  endtask

  initial begin
    int dims[3];
    sb = new();
    calm = 0;
    issued = 0;
    rst = 1;
    req_ch.valid = 0;
    req_ch.data = '0;
    cfg_ch.valid = 0;
    cfg_ch.data = '0;
    rsp_ch.ready = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Positive saturation on a single entry, then negative
    set_dims(1, 1, 1);
    directed_item(CMD_LOAD_A, 0, 0, -16'sd32768, '0);
    directed_item(CMD_LOAD_B, 0, 0, -16'sd32768, '0);
    directed_item(CMD_LOAD_C, 0, 0, '0, 32'h7FFFFFFF);
    directed_item(CMD_COMPUTE, 0, 0, '0, '0);
    directed_item(CMD_LOAD_B, 0, 0, 16'sd32767, '0);
    directed_item(CMD_LOAD_C, 0, 0, '0, 32'h80000000);
    directed_item(CMD_COMPUTE, 7, 7, -16'sd1, -32'sd1);
    // Far corner loads
    directed_item(CMD_LOAD_A, 7, 7, 16'sd32767, '0);
    directed_item(CMD_LOAD_C, 7, 7, '0, 32'h7FFFFFFF);
    wait_idle();
    // Empty dot product: entries equal the stored C
    set_dims(2, 0, 2);
    fill_and_compute();
    wait_idle();
    // Zero rows or columns emit nothing
    set_dims(0, 3, 3);
    fill_and_compute();
    wait_idle();
    set_dims(3, 3, 0);
    fill_and_compute();
    wait_idle();

    // Random phases: mostly small shapes, occasionally full size or oversized
    for (int phase = 0; issued < 450; phase++) begin
      calm = (phase == 4);
      for (int d = 0; d < 3; d++)
        case ($urandom_range(9))
          0: dims[d] = 0;
          1: dims[d] = 8;
          2: dims[d] = $urandom_range(15, 9);
          default: dims[d] = $urandom_range(4, 1);
        endcase
      if (phase == 2) dims = '{15, 15, 15};
      if (phase == 6) dims = '{8, 8, 8};
      set_dims(dims[0], dims[1], dims[2]);
      repeat ($urandom_range(3, 1)) begin
        repeat ($urandom_range(12)) load_one(CMD_W'($urandom_range(2)), $urandom_range(7),
                                              $urandom_range(7));
        fill_and_compute();
      end
      wait_idle();
    end
    calm = 0;

    $display("%0d requests with %0d computes; %0d result entries checked, %0d saturated",
             issued, sb.computes, sb.results, sb.sat_seen);
    if (sb.errors == 0 && sb.entries_due.size() == 0) begin
      $display("matrix_multiply_accumulate: match");
    end else begin
      $display("%0d errors, %0d entries never arrived", sb.errors, sb.entries_due.size());
      $display("matrix_multiply_accumulate: mismatch");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #50000000;
    $display("timeout");
    $display("matrix_multiply_accumulate: mismatch");
    $finish;
  end

endmodule

// File: files.f
sv/mma_pkg.sv
sv/mma_if.sv
sv/mma_ram.sv
sv/mma_cell.sv
sv/matrix_multiply_accumulate.sv
tb/testbench.sv
